/* hdl/clock_time_setting_controller_assert.svh */
// Assertion macros for the clock time setting controller
`ifndef CLOCK_TIME_SETTING_CONTROLLER_ASSERT_SVH
`define CLOCK_TIME_SETTING_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a condition holds on every clock edge out of reset
`define CTSC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed: condition does not hold");

// Check that the consequent holds in the same cycle as the antecedent
`define CTSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication does not hold");

// Check that the consequent holds in the cycle after the antecedent
`define CTSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication does not hold");

`else

`define CTSC_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define CTSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define CTSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/ctsc_pkg.sv */
// Types, constants and step functions for the clock time setting controller
`default_nettype none

package ctsc_pkg;

	// Event kinds carried in the input tuser
	typedef enum logic [1:0] {
		OP_FORWARD  = 2'd0,
		OP_BACKWARD = 2'd1,
		OP_PRESS    = 2'd2
	} op_t;

	// Cursor positions
	localparam logic [2:0] CUR_YEAR   = 3'd0;
	localparam logic [2:0] CUR_MONTH  = 3'd1;
	localparam logic [2:0] CUR_DAY    = 3'd2;
	localparam logic [2:0] CUR_HOUR   = 3'd3;
	localparam logic [2:0] CUR_MINUTE = 3'd4;
	localparam logic [2:0] CUR_SECOND = 3'd5;

	// Field limits
	localparam logic [7:0] YEAR_MAX   = 8'd255;
	localparam logic [7:0] MONTH_MAX  = 8'd11;
	localparam logic [7:0] DAY_MAX    = 8'd31;
	localparam logic [7:0] HOUR_MAX   = 8'd23;
	localparam logic [7:0] MINSEC_MAX = 8'd59;
	localparam logic [7:0] DAY_LOW    = 8'd1;
	localparam logic [7:0] ZERO_LOW   = 8'd0;

	// Edited time fields
	typedef struct packed {
		logic [7:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} fields_t;

	// Forward step: wrap to low once the value passes max
	function automatic logic [7:0] wrap_up(logic [7:0] v, logic [7:0] low, logic [7:0] max);
		logic [8:0] inc;
		inc = {1'b0, v} + 9'd1;
		return (inc > {1'b0, max}) ? low : inc[7:0];
	endfunction

	// Backward step: wrap to max at or below low
	function automatic logic [7:0] wrap_down(logic [7:0] v, logic [7:0] low, logic [7:0] max);
		return (v <= low) ? max : v - 8'd1;
	endfunction

endpackage

`default_nettype wire

/* hdl/clock_time_setting_controller.sv */
// Rotary encoder time setting controller: state update and registered result
//
//  Channel  | Direction | Handshake                    | Contents
//  ---------+-----------+------------------------------+-------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | event kind, current clock time
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | mode, cursor, edited time, commit
//
// One item per cycle unless m_axis stalls; results show in the cycle after items are taken.
// The state update is a single increment or decrement with a wrap or clamp compare, and
// the result register takes the next item in the same cycle as its predecessor leaves.
// Reset puts the block in normal mode, cursor on the year, edited time all zero.
// A stall on m_axis holds the result; s_axis_tready drops only while it is full.
`default_nettype none

`include "clock_time_setting_controller_assert.svh"

module clock_time_setting_controller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// now_year[7:0], now_month[11:8], now_day[16:12], now_hour[21:17],
	// now_minute[27:22], now_second[33:28], zero[39:34]
	input  wire logic [39:0] s_axis_tdata,
	// operation[1:0]
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// in_setting[0], cursor[3:1], set_year[11:4], set_month[15:12], set_day[20:16],
	// set_hour[25:21], set_minute[31:26], set_second[37:32], zero[39:38]
	output logic [39:0]      m_axis_tdata,
	// commit[0]
	output logic [0:0]       m_axis_tuser
);

	logic              mode_q;
	logic [2:0]        cursor_q;
	ctsc_pkg::fields_t edit_q;

	logic              mode_d;
	logic [2:0]        cursor_d;
	ctsc_pkg::fields_t edit_d;
	logic              commit_d;

	logic              out_valid_q;
	logic [39:0]       out_data_q;
	logic              out_commit_q;

	ctsc_pkg::op_t     op;
	ctsc_pkg::fields_t now;
	logic              fwd;
	logic              in_accept;

	logic              chk_commit;
	logic              chk_press;
	logic              chk_loaded;

	// Unpack the incoming item
	assign op         = ctsc_pkg::op_t'(s_axis_tuser);
	assign now.year   = s_axis_tdata[7:0];
	assign now.month  = s_axis_tdata[11:8];
	assign now.day    = s_axis_tdata[16:12];
	assign now.hour   = s_axis_tdata[21:17];
	assign now.minute = s_axis_tdata[27:22];
	assign now.second = s_axis_tdata[33:28];
	assign fwd        = (op == ctsc_pkg::OP_FORWARD);

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// Work out the next state for one item
	always_comb begin
		mode_d   = mode_q;
		cursor_d = cursor_q;
		edit_d   = edit_q;
		commit_d = 1'b0;
		case (op)
			ctsc_pkg::OP_FORWARD, ctsc_pkg::OP_BACKWARD: begin
				// edit the field under the cursor
				case (cursor_q)
					ctsc_pkg::CUR_YEAR: begin
						if (fwd) begin
							if (edit_q.year != ctsc_pkg::YEAR_MAX)
								edit_d.year = edit_q.year + 8'd1;
						end else begin
							if (edit_q.year != 8'd0)
								edit_d.year = edit_q.year - 8'd1;
						end
					end
					ctsc_pkg::CUR_MONTH: begin
						edit_d.month = fwd
							? 4'(ctsc_pkg::wrap_up({4'd0, edit_q.month},
								ctsc_pkg::ZERO_LOW, ctsc_pkg::MONTH_MAX))
							: 4'(ctsc_pkg::wrap_down({4'd0, edit_q.month},
								ctsc_pkg::ZERO_LOW, ctsc_pkg::MONTH_MAX));
					end
					ctsc_pkg::CUR_DAY: begin
						edit_d.day = fwd
							? 5'(ctsc_pkg::wrap_up({3'd0, edit_q.day},
								ctsc_pkg::DAY_LOW, ctsc_pkg::DAY_MAX))
							: 5'(ctsc_pkg::wrap_down({3'd0, edit_q.day},
								ctsc_pkg::DAY_LOW, ctsc_pkg::DAY_MAX));
					end
					ctsc_pkg::CUR_HOUR: begin
						edit_d.hour = fwd
							? 5'(ctsc_pkg::wrap_up({3'd0, edit_q.hour},
								ctsc_pkg::ZERO_LOW, ctsc_pkg::HOUR_MAX))
							: 5'(ctsc_pkg::wrap_down({3'd0, edit_q.hour},
								ctsc_pkg::ZERO_LOW, ctsc_pkg::HOUR_MAX));
					end
					ctsc_pkg::CUR_MINUTE: begin
						edit_d.minute = fwd
							? 6'(ctsc_pkg::wrap_up({2'd0, edit_q.minute},
								ctsc_pkg::ZERO_LOW, ctsc_pkg::MINSEC_MAX))
							: 6'(ctsc_pkg::wrap_down({2'd0, edit_q.minute},
								ctsc_pkg::ZERO_LOW, ctsc_pkg::MINSEC_MAX));
					end
					ctsc_pkg::CUR_SECOND: begin
						edit_d.second = fwd
							? 6'(ctsc_pkg::wrap_up({2'd0, edit_q.second},
								ctsc_pkg::ZERO_LOW, ctsc_pkg::MINSEC_MAX))
							: 6'(ctsc_pkg::wrap_down({2'd0, edit_q.second},
								ctsc_pkg::ZERO_LOW, ctsc_pkg::MINSEC_MAX));
					end
					default: begin
					end
				endcase
			end
			ctsc_pkg::OP_PRESS: begin
				if (!mode_q) begin
					// load the clock time and start editing at the year
					edit_d   = now;
					cursor_d = ctsc_pkg::CUR_YEAR;
					mode_d   = 1'b1;
				end else if (cursor_q >= ctsc_pkg::CUR_SECOND) begin
					commit_d = 1'b1;
					mode_d   = 1'b0;
				end else begin
					cursor_d = cursor_q + 3'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// Hold the state; advance it on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			cursor_q <= ctsc_pkg::CUR_YEAR;
			edit_q   <= '0;
		end else if (in_accept) begin
			mode_q   <= mode_d;
			cursor_q <= cursor_d;
			edit_q   <= edit_d;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			out_data_q   <= {2'd0, edit_d.second, edit_d.minute, edit_d.hour, edit_d.day,
				edit_d.month, edit_d.year, cursor_d, mode_d};
			out_commit_q <= commit_d;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_commit_q;

	// Terms for the checks
	assign chk_commit = m_axis_tvalid && m_axis_tuser[0];
	assign chk_press  = in_accept && (op == ctsc_pkg::OP_PRESS) && !mode_q;
	assign chk_loaded = mode_q && (cursor_q == ctsc_pkg::CUR_YEAR);

	// Checks
	`CTSC_ASSERT_ALWAYS(a_cursor_range, clk, arst_n, cursor_q <= ctsc_pkg::CUR_SECOND)
	`CTSC_ASSERT_IMPL(a_commit_leaves_setting, clk, arst_n, chk_commit, !m_axis_tdata[0])
	`CTSC_ASSERT_NEXT(a_press_enters_setting, clk, arst_n, chk_press, chk_loaded)

endmodule

`default_nettype wire
